[hdl/smd_pkg.sv]
// Shared constants for the sorted merge with duplicate removal block.
package smd_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 6;
  localparam int FUNC_W     = 2;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MERGE  = 2'd2;

endpackage

[hdl/smd_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
module smd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/sorted_merge_dedup.sv]
// Top level: loads two sorted lists and merges them into one strictly increasing run.
//
// A load beat (in_func 0 or 1) gives no result; a load into a full list is dropped and
// flagged through out_overflow of the next run. A merge beat walks both list memories
// with one comparison per cycle, keeping busy high through the walk and a final flush;
// results leave one per cycle at most, each held on the out_ ports for one cycle under
// out_valid, and the final one carries out_last_of_run as busy falls. A merge over two
// empty lists gives a single result with out_is_empty in the cycle after the beat. The
// receiver cannot stall: out_valid is never held off.
module sorted_merge_dedup (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic        [smd_pkg::FUNC_W-1:0]  in_func,
  input  logic signed [smd_pkg::VAL_W-1:0]   in_value,
  output logic                               out_valid,
  output logic signed [smd_pkg::VAL_W-1:0]   out_merged_value,
  output logic        [smd_pkg::POS_W-1:0]   out_position,
  output logic                               out_is_empty,
  output logic                               out_overflow,
  output logic                               out_last_of_run
);
  import smd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic                drop_r, drop_nxt, ovf_r, ovf_nxt;
  logic                have_r, have_nxt;
  logic [VAL_W-1:0]    pend_val_r, pend_val_nxt;
  logic [POS_W-1:0]    pend_pos_r, pend_pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_val_r, out_val_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic                out_empty_r, out_empty_nxt, out_last_r, out_last_nxt;

  logic                we_a, we_b;
  logic [VAL_W-1:0]    a_rd, b_rd, pick;
  logic                a_ok, b_ok, take_a, emit;

  smd_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (i_nxt[ADDR_W-1:0]),
    .rdata (a_rd)
  );

  smd_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (j_nxt[ADDR_W-1:0]),
    .rdata (b_rd)
  );

  assign a_ok   = i_r < cnt_a_r;
  assign b_ok   = j_r < cnt_b_r;
  assign take_a = a_ok && (!b_ok || ($signed(a_rd) < $signed(b_rd)));
  assign pick   = take_a ? a_rd : b_rd;
  assign emit   = !have_r || ($signed(pend_val_r) < $signed(pick));

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    drop_nxt      = drop_r;
    ovf_nxt       = ovf_r;
    have_nxt      = have_r;
    pend_val_nxt  = pend_val_r;
    pend_pos_nxt  = pend_pos_r;
    out_valid_nxt = 1'b0;
    out_val_nxt   = out_val_r;
    out_pos_nxt   = out_pos_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    we_a          = 1'b0;
    we_b          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        if (start) begin
          case (in_func)
            FUNC_LOAD_A: begin
              if (cnt_a_r < CNT_W'(LIST_DEPTH)) begin
                we_a      = 1'b1;
                cnt_a_nxt = cnt_a_r + CNT_W'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            FUNC_LOAD_B: begin
              if (cnt_b_r < CNT_W'(LIST_DEPTH)) begin
                we_b      = 1'b1;
                cnt_b_nxt = cnt_b_r + CNT_W'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            FUNC_MERGE: begin
              ovf_nxt  = drop_r;
              drop_nxt = 1'b0;
              have_nxt = 1'b0;
              if (cnt_a_r == '0 && cnt_b_r == '0) begin
                out_valid_nxt = 1'b1;
                out_val_nxt   = '0;
                out_pos_nxt   = '0;
                out_empty_nxt = 1'b1;
                out_last_nxt  = 1'b1;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        i_nxt = i_r + CNT_W'(take_a);
        j_nxt = j_r + CNT_W'(!take_a);
        if (emit) begin
          have_nxt     = 1'b1;
          pend_val_nxt = pick;
          pend_pos_nxt = have_r ? pend_pos_r + POS_W'(1) : '0;
          if (have_r) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = pend_val_r;
            out_pos_nxt   = pend_pos_r;
            out_empty_nxt = 1'b0;
            out_last_nxt  = 1'b0;
          end
        end
        if (i_nxt == cnt_a_r && j_nxt == cnt_b_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = pend_val_r;
        out_pos_nxt   = pend_pos_r;
        out_empty_nxt = 1'b0;
        out_last_nxt  = 1'b1;
        cnt_a_nxt     = '0;
        cnt_b_nxt     = '0;
        i_nxt         = '0;
        j_nxt         = '0;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      drop_r      <= 1'b0;
      ovf_r       <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      drop_r      <= drop_nxt;
      ovf_r       <= ovf_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_val_r  <= pend_val_nxt;
    pend_pos_r  <= pend_pos_nxt;
    out_val_r   <= out_val_nxt;
    out_pos_r   <= out_pos_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_merged_value = out_val_r;
  assign out_position     = out_pos_r;
  assign out_is_empty     = out_empty_r;
  assign out_overflow     = ovf_r;
  assign out_last_of_run  = out_last_r;

  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_last_of_run && out_position == '0)
    else $error("empty run result is not a single final beat");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> !busy)
    else $error("busy still high with the final beat of a run");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CNT_W'(LIST_DEPTH) && cnt_b_r <= CNT_W'(LIST_DEPTH))
    else $error("list count beyond depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> a_ok || b_ok)
    else $error("walk step with both lists used up");

endmodule

[test/tb_sorted_merge_dedup.sv]
// Testbench for sorted_merge_dedup: loads list pairs, predicts each merged run, checks results.
module tb_sorted_merge_dedup;
  import smd_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    logic is_empty;
    logic overflow;
    logic at_end;
  } run_beat_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic signed [VAL_W-1:0] out_merged_value;
  logic [POS_W-1:0] out_position;
  logic out_is_empty;
  logic out_overflow;
  logic out_last_of_run;

  logic signed [VAL_W-1:0] list_a [LIST_DEPTH];
  logic signed [VAL_W-1:0] list_b [LIST_DEPTH];
  int fill_a = 0;
  int fill_b = 0;
  bit lost_load = 1'b0;
  run_beat_t expected_run [$];

  int mismatches = 0;
  int beats_counted = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  sorted_merge_dedup dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_merged_value(out_merged_value),
    .out_position(out_position),
    .out_is_empty(out_is_empty),
    .out_overflow(out_overflow),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic merge_lists();
    run_beat_t held;
    logic signed [VAL_W-1:0] pick;
    logic signed [VAL_W-1:0] last_val;
    int ia;
    int ib;
    int n;
    ia = 0;
    ib = 0;
    n = 0;
    last_val = '0;
    if (fill_a == 0 && fill_b == 0) begin
      held = {32'sd0, 6'd0, 1'b1, lost_load, 1'b1};
    end else begin
      while (ia < fill_a || ib < fill_b) begin
        if (ia < fill_a && (ib >= fill_b || list_a[ia] < list_b[ib])) begin
          pick = list_a[ia];
          ia++;
        end else begin
          pick = list_b[ib];
          ib++;
        end
        if (n == 0 || last_val < pick) begin
          if (n > 0) expected_run.push_back(held);
          held = {pick, POS_W'(n), 1'b0, lost_load, 1'b0};
          last_val = pick;
          n++;
        end
      end
      held.at_end = 1'b1;
    end
    expected_run.push_back(held);
    fill_a = 0;
    fill_b = 0;
    lost_load = 1'b0;
  endtask

  task automatic update_lists(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v);
    case (f)
      FUNC_LOAD_A: begin
        if (fill_a < LIST_DEPTH) begin
          list_a[fill_a] = v;
          fill_a++;
        end else begin
          lost_load = 1'b1;
        end
      end
      FUNC_LOAD_B: begin
        if (fill_b < LIST_DEPTH) begin
          list_b[fill_b] = v;
          fill_b++;
        end else begin
          lost_load = 1'b1;
        end
      end
      FUNC_MERGE: merge_lists();
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 6);
    if (r < 90) return $urandom_range(7, 20);
    return $urandom_range(30, 35);
  endfunction

  function automatic longint step_up(longint cur, longint stepmax);
    longint n;
    n = cur + longint'($urandom_range(0, int'(stepmax)));
    return (n > VAL_MAX) ? VAL_MAX : n;
  endfunction

  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v);
    int gap;
    start <= 1'b1;
    in_func <= f;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    update_lists(f, v);
    if (f != FUNC_UNUSED) beats_counted++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_run_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_run.size() != 0);
  endtask

  task automatic load_sets(input int na, input int nb, input bit ordered);
    longint cur_a;
    longint cur_b;
    longint stepmax;
    int ia;
    int ib;
    int mode;
    ia = 0;
    ib = 0;
    mode = $urandom_range(0, 3);
    case (mode)
      0: stepmax = 2;
      1: stepmax = 1000;
      2: stepmax = 64'd1 << 27;
      default: stepmax = 64'd1 << 28;
    endcase
    cur_a = (mode == 3) ? VAL_MIN : longint'($signed($urandom()));
    cur_b = $urandom_range(0, 1) ? cur_a : longint'($signed($urandom()));
    steady = ($urandom_range(0, 3) == 0);
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1))) begin
        if (ordered) begin
          send_beat(FUNC_LOAD_A, cur_a[VAL_W-1:0]);
          cur_a = step_up(cur_a, stepmax);
        end else begin
          send_beat(FUNC_LOAD_A, $urandom());
        end
        ia++;
      end else begin
        if (ordered) begin
          send_beat(FUNC_LOAD_B, cur_b[VAL_W-1:0]);
          cur_b = step_up(cur_b, stepmax);
        end else begin
          send_beat(FUNC_LOAD_B, $urandom());
        end
        ib++;
      end
    end
    send_beat(FUNC_MERGE, $urandom());
  endtask

  task automatic test_empty_merge();
    send_beat(FUNC_MERGE, 32'sd0);
    send_beat(FUNC_UNUSED, 32'sh7FFF_FFFF);
    send_beat(FUNC_MERGE, -32'sd1);
  endtask

  task automatic test_extremes_and_ties();
    send_beat(FUNC_LOAD_A, 32'sh8000_0000);
    send_beat(FUNC_LOAD_B, 32'sh8000_0000);
    send_beat(FUNC_LOAD_A, -32'sd1);
    send_beat(FUNC_LOAD_A, 32'sd0);
    send_beat(FUNC_LOAD_B, 32'sd0);
    send_beat(FUNC_LOAD_B, 32'sd1);
    send_beat(FUNC_LOAD_A, 32'sh7FFF_FFFF);
    send_beat(FUNC_LOAD_B, 32'sh7FFF_FFFF);
    send_beat(FUNC_MERGE, 32'sh5555_AAAA);
  endtask

  task automatic test_single_list();
    send_beat(FUNC_LOAD_A, 32'sd5);
    send_beat(FUNC_LOAD_A, 32'sd5);
    send_beat(FUNC_LOAD_A, 32'sd7);
    send_beat(FUNC_MERGE, 32'sd0);
    send_beat(FUNC_LOAD_B, -32'sd3);
    send_beat(FUNC_LOAD_B, -32'sd3);
    send_beat(FUNC_MERGE, 32'sd0);
  endtask

  task automatic test_unsorted_lists();
    send_beat(FUNC_LOAD_A, 32'sd10);
    send_beat(FUNC_LOAD_A, 32'sd3);
    send_beat(FUNC_LOAD_B, 32'sd15);
    send_beat(FUNC_LOAD_A, 32'sd20);
    send_beat(FUNC_LOAD_B, 32'sd1);
    send_beat(FUNC_MERGE, 32'sd0);
  endtask

  task automatic test_full_lists();
    longint base;
    base = VAL_MIN + longint'($urandom_range(0, 32'hFFFF_FF00));
    for (int k = 0; k <= LIST_DEPTH; k++) begin
      send_beat(FUNC_LOAD_A, VAL_W'(base + 2 * k));
      send_beat(FUNC_LOAD_B, VAL_W'(base + 2 * k + 1));
    end
    send_beat(FUNC_MERGE, $urandom());
    wait_run_drained();
  endtask

  task automatic test_sorted_runs();
    while (beats_counted < 380) begin
      load_sets(pick_len(), pick_len(), 1'b1);
      if ($urandom_range(0, 9) == 0) wait_run_drained();
    end
  endtask

  task automatic test_unsorted_runs();
    while (beats_counted < 430) begin
      load_sets($urandom_range(0, 8), $urandom_range(0, 8), 1'b0);
    end
  endtask

  task automatic test_noise_beats();
    steady = 1'b0;
    while (beats_counted < 470) begin
      send_beat(FUNC_W'($urandom_range(0, 3)), $urandom());
    end
    send_beat(FUNC_MERGE, $urandom());
  endtask

  always @(posedge clk) begin : check_results
    run_beat_t exp_beat;
    if (rst_n && out_valid) begin
      if (expected_run.size() == 0) begin
        $display("%0t unexpected result: expected none, got value %0d pos %0d",
                 $time, out_merged_value, out_position);
        mismatches++;
      end else begin
        exp_beat = expected_run.pop_front();
        if (out_merged_value !== exp_beat.value) begin
          $display("%0t merged_value: expected %0d, got %0d",
                   $time, $signed(exp_beat.value), out_merged_value);
          mismatches++;
        end
        if (out_position !== exp_beat.pos) begin
          $display("%0t position: expected %0d, got %0d", $time, exp_beat.pos, out_position);
          mismatches++;
        end
        if (out_is_empty !== exp_beat.is_empty) begin
          $display("%0t is_empty: expected %0b, got %0b", $time, exp_beat.is_empty, out_is_empty);
          mismatches++;
        end
        if (out_overflow !== exp_beat.overflow) begin
          $display("%0t overflow: expected %0b, got %0b", $time, exp_beat.overflow, out_overflow);
          mismatches++;
        end
        if (out_last_of_run !== exp_beat.at_end) begin
          $display("%0t last_of_run: expected %0b, got %0b",
                   $time, exp_beat.at_end, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_merge();
    test_extremes_and_ties();
    test_single_list();
    test_unsorted_lists();
    test_full_lists();
    test_sorted_runs();
    test_unsorted_runs();
    test_noise_beats();
    wait_run_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
